// ===== rtl/irwfs_pkg.sv =====
// Shared constants, tables and helper functions of the wall-following steering block.
`default_nettype none
package irwfs_pkg;

  // Default geometry, all Q8.8.
  localparam int DEF_SENSOR_SPACING     = 4096;
  localparam int DEF_FRONT_MOUNT_OFFSET = 0;
  localparam int DEF_REAR_MOUNT_OFFSET  = 0;

  // Configuration register indexes.
  localparam logic [2:0] REG_FRONT_SCALE     = 3'd0;
  localparam logic [2:0] REG_FRONT_BIAS      = 3'd1;
  localparam logic [2:0] REG_REAR_SCALE      = 3'd2;
  localparam logic [2:0] REG_REAR_BIAS       = 3'd3;
  localparam logic [2:0] REG_TARGET_DISTANCE = 3'd4;
  localparam logic [2:0] REG_DISTANCE_GAIN   = 3'd5;
  localparam logic [2:0] REG_ANGLE_GAIN      = 3'd6;
  localparam logic [2:0] REG_BASE_SPEED      = 3'd7;

  localparam int CORDIC_STEPS = 15;
  localparam int ANGLE_LIMIT  = 25736;
  localparam int ALIGN_LIMIT  = 3276;
  localparam int NEAR_LIMIT   = 2560;
  localparam int INV_GAIN_Q14 = 9949;

  // Divider geometry: numerator is scale shifted up by eight bits.
  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 11;

  // Stage counts of each section.
  localparam int DIV_LAT  = DIV_NUM_W + 2;
  localparam int ATAN_LAT = CORDIC_STEPS + 2;
  localparam int COS_LAT  = CORDIC_STEPS + 1;
  localparam int TAIL_LAT = 5;
  localparam int PIPE_LAT = DIV_LAT + ATAN_LAT + COS_LAT + TAIL_LAT;

  localparam int WIDE_W = 42;

  // Arctangent of 2^-i in Q2.14.
  function automatic logic [13:0] atan_q14(input int unsigned i);
    logic [13:0] r;
    case (i)
      0:       r = 14'd12868;
      1:       r = 14'd7596;
      2:       r = 14'd4014;
      3:       r = 14'd2037;
      4:       r = 14'd1023;
      5:       r = 14'd512;
      6:       r = 14'd256;
      7:       r = 14'd128;
      8:       r = 14'd64;
      9:       r = 14'd32;
      10:      r = 14'd16;
      11:      r = 14'd8;
      12:      r = 14'd4;
      13:      r = 14'd2;
      14:      r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

  // Saturates a wide signed value into 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [15:0] r;
    if (v > 42'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -42'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/irwfs_div.sv =====
// Pipelined restoring divider that turns one IR sample into a distance.
`default_nettype none
module irwfs_div #(
  parameter int OFFSET = 0
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [9:0]         sample,
  input  wire logic [15:0]        scale,
  input  wire logic signed [9:0]  bias,
  output logic signed [15:0]      distance
);
  import irwfs_pkg::*;

  localparam int NB = DIV_NUM_W;
  localparam int DW = DIV_DEN_W;

  logic [NB-1:0] nm   [0:NB];
  logic [NB-1:0] quo  [0:NB];
  logic [DW-1:0] dm   [0:NB-1];
  logic [DW-1:0] rem  [0:NB-1];
  logic          neg  [0:NB];
  logic          zero [0:NB];

  logic signed [11:0] den;
  logic signed [17:0] qs;
  logic signed [17:0] qo;

  assign den = $signed({2'b00, sample}) + 12'(bias);

  always_ff @(posedge clk) begin
    if (en) begin
      nm[0]   <= {scale, 8'd0};
      quo[0]  <= '0;
      rem[0]  <= '0;
      dm[0]   <= den[11] ? DW'(-den) : DW'(den);
      neg[0]  <= den[11];
      zero[0] <= (den == 12'sd0);
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < NB; k++) begin : g_step
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem[k], nm[k][NB-1-k]};
    assign ge    = (trial >= {1'b0, dm[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        nm[k+1]   <= nm[k];
        quo[k+1]  <= {quo[k][NB-2:0], ge};
        neg[k+1]  <= neg[k];
        zero[k+1] <= zero[k];
      end
    end
    if (k < NB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dm[k+1]  <= dm[k];
          rem[k+1] <= ge ? DW'(trial - {1'b0, dm[k]}) : trial[DW-1:0];
        end
      end
    end
  end

  always_comb begin
    if (zero[NB]) begin
      qs = (nm[NB] != '0) ? 18'sd32767 : 18'sd0;
    end else if (neg[NB]) begin
      qs = (quo[NB] > NB'(32768)) ? -18'sd32768 : -$signed({1'b0, quo[NB][16:0]});
    end else begin
      qs = (quo[NB] > NB'(32767)) ? 18'sd32767 : $signed({1'b0, quo[NB][16:0]});
    end
    qo = qs - 18'(OFFSET);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      distance <= sat16(WIDE_W'(qo));
    end
  end

endmodule
`default_nettype wire

// ===== rtl/irwfs_atan.sv =====
// Pipelined CORDIC in vectoring mode giving the clamped wall angle.
`default_nettype none
module irwfs_atan #(
  parameter int SPACING = 4096
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [16:0] diff,
  input  wire logic signed [15:0] mean_in,
  output logic signed [15:0]      angle,
  output logic signed [15:0]      mean_out
);
  import irwfs_pkg::*;

  localparam int N  = CORDIC_STEPS;
  localparam int CW = 32;
  localparam int ZW = 18;

  logic signed [CW-1:0] x    [0:N];
  logic signed [CW-1:0] y    [0:N];
  logic signed [ZW-1:0] z    [0:N];
  logic                 zf   [0:N];
  logic signed [15:0]   mean [0:N];
  logic signed [ZW-1:0] nz;

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= CW'(SPACING * 4096);
      y[0]    <= CW'(diff) <<< 12;
      z[0]    <= '0;
      zf[0]   <= (diff == 17'sd0);
      mean[0] <= mean_in;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic signed [ZW-1:0] t;
    assign t = $signed({4'b0000, atan_q14(k)});
    always_ff @(posedge clk) begin
      if (en) begin
        if (y[k] >= 0) begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          z[k+1] <= z[k] + t;
        end else begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          z[k+1] <= z[k] - t;
        end
        zf[k+1]   <= zf[k];
        mean[k+1] <= mean[k];
      end
    end
  end

  assign nz = -z[N];

  always_ff @(posedge clk) begin
    if (en) begin
      if (zf[N]) begin
        angle <= '0;
      end else if (nz > ZW'(ANGLE_LIMIT)) begin
        angle <= 16'(ANGLE_LIMIT);
      end else if (nz < -ZW'(ANGLE_LIMIT)) begin
        angle <= -16'(ANGLE_LIMIT);
      end else begin
        angle <= nz[15:0];
      end
      mean_out <= mean[N];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/irwfs_cos.sv =====
// Pipelined CORDIC in rotation mode giving the cosine of the wall angle.
`default_nettype none
module irwfs_cos (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [15:0] angle_in,
  input  wire logic signed [15:0] mean_in,
  output logic signed [17:0]      cosv,
  output logic signed [15:0]      angle_out,
  output logic signed [15:0]      mean_out
);
  import irwfs_pkg::*;

  localparam int N  = CORDIC_STEPS;
  localparam int CW = 26;
  localparam int ZW = 18;

  logic signed [CW-1:0] x    [0:N];
  logic signed [CW-1:0] y    [0:N];
  logic signed [ZW-1:0] z    [0:N];
  logic signed [15:0]   ang  [0:N];
  logic signed [15:0]   mean [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= CW'(INV_GAIN_Q14 * 256);
      y[0]    <= '0;
      z[0]    <= ZW'(angle_in);
      ang[0]  <= angle_in;
      mean[0] <= mean_in;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic signed [ZW-1:0] t;
    assign t = $signed({4'b0000, atan_q14(k)});
    always_ff @(posedge clk) begin
      if (en) begin
        if (z[k] >= 0) begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          z[k+1] <= z[k] - t;
        end else begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          z[k+1] <= z[k] + t;
        end
        ang[k+1]  <= ang[k];
        mean[k+1] <= mean[k];
      end
    end
  end

  // Result scaled from Q2.22 down to Q2.14.
  assign cosv      = 18'(x[N] >>> 8);
  assign angle_out = ang[N];
  assign mean_out  = mean[N];

endmodule
`default_nettype wire

// ===== rtl/ir_wall_follow_steering.sv =====
// Top level of the IR wall-following steering pipeline.
`default_nettype none
//  Channel  | Direction | Handshake             | Payload
//  in       | sink      | in_valid / in_ready   | front_sample, rear_sample
//  out      | source    | out_valid / out_ready | wheel speeds, wall_distance, wall_angle, flags
//  cfg      | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One sensor pair can be taken in every cycle in which the output is not held; each result
// passes through the 24 quotient stages of the dividers and the two 15-step CORDIC
// pipelines. Reset clears the configuration registers and all stage valid bits.
// The whole pipeline advances together: when a result waits at the output, every stage
// holds, and no item is lost or repeated. Configuration writes are taken in any cycle.
module ir_wall_follow_steering #(
  parameter int SENSOR_SPACING     = irwfs_pkg::DEF_SENSOR_SPACING,
  parameter int FRONT_MOUNT_OFFSET = irwfs_pkg::DEF_FRONT_MOUNT_OFFSET,
  parameter int REAR_MOUNT_OFFSET  = irwfs_pkg::DEF_REAR_MOUNT_OFFSET
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [9:0]         front_sample,
  input  wire logic [9:0]         rear_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      right_wheel_speed,
  output logic signed [15:0]      left_wheel_speed,
  output logic signed [15:0]      wall_distance,
  output logic signed [15:0]      wall_angle,
  output logic                    near_wall,
  output logic                    aligned,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import irwfs_pkg::*;

  // Configuration registers.
  logic [15:0]        front_scale;
  logic signed [9:0]  front_bias;
  logic [15:0]        rear_scale;
  logic signed [9:0]  rear_bias;
  logic [15:0]        target_distance;
  logic [15:0]        distance_gain;
  logic [15:0]        angle_gain;
  logic signed [15:0] base_speed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_scale     <= '0;
      front_bias      <= '0;
      rear_scale      <= '0;
      rear_bias       <= '0;
      target_distance <= '0;
      distance_gain   <= '0;
      angle_gain      <= '0;
      base_speed      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRONT_SCALE:     front_scale     <= cfg_data;
        REG_FRONT_BIAS:      front_bias      <= cfg_data[9:0];
        REG_REAR_SCALE:      rear_scale      <= cfg_data;
        REG_REAR_BIAS:       rear_bias       <= cfg_data[9:0];
        REG_TARGET_DISTANCE: target_distance <= cfg_data;
        REG_DISTANCE_GAIN:   distance_gain   <= cfg_data;
        REG_ANGLE_GAIN:      angle_gain      <= cfg_data;
        REG_BASE_SPEED:      base_speed      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valid bits; the pipeline moves whenever the output register is free or drained.
  logic [PIPE_LAT-1:0] vld;
  logic                adv;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  // Sensor distances.
  logic signed [15:0] front_dist;
  logic signed [15:0] rear_dist;

  irwfs_div #(.OFFSET(FRONT_MOUNT_OFFSET)) u_front (
    .clk(clk), .en(adv), .sample(front_sample), .scale(front_scale),
    .bias(front_bias), .distance(front_dist)
  );

  irwfs_div #(.OFFSET(REAR_MOUNT_OFFSET)) u_rear (
    .clk(clk), .en(adv), .sample(rear_sample), .scale(rear_scale),
    .bias(rear_bias), .distance(rear_dist)
  );

  // Difference and floor mean of the two distances.
  logic signed [16:0] diff;
  logic signed [15:0] mean;
  logic signed [16:0] sum;

  assign sum = 17'(front_dist) + 17'(rear_dist);

  always_ff @(posedge clk) begin
    if (adv) begin
      diff <= 17'(front_dist) - 17'(rear_dist);
      mean <= sum[16:1];
    end
  end

  logic signed [15:0] angle_a;
  logic signed [15:0] mean_a;

  irwfs_atan #(.SPACING(SENSOR_SPACING)) u_atan (
    .clk(clk), .en(adv), .diff(diff), .mean_in(mean),
    .angle(angle_a), .mean_out(mean_a)
  );

  logic signed [17:0] cosv;
  logic signed [15:0] angle_c;
  logic signed [15:0] mean_c;

  irwfs_cos u_cos (
    .clk(clk), .en(adv), .angle_in(angle_a), .mean_in(mean_a),
    .cosv(cosv), .angle_out(angle_c), .mean_out(mean_c)
  );

  // Projected distance product.
  logic signed [33:0] prod;
  logic signed [15:0] angle_p;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod    <= 34'(mean_c) * 34'(cosv);
      angle_p <= angle_c;
    end
  end

  // Distance, error and the two gating flags.
  logic signed [15:0] dist_e;
  logic signed [17:0] err_comb;
  logic signed [17:0] err_e;
  logic signed [15:0] angle_e;
  logic               near_e;
  logic               aligned_e;
  logic signed [15:0] dist_comb;

  assign dist_comb = sat16(WIDE_W'(prod >>> 14));
  assign err_comb  = 18'(dist_comb) - $signed({2'b00, target_distance});

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_e    <= dist_comb;
      err_e     <= err_comb;
      angle_e   <= angle_p;
      near_e    <= (err_comb >= -18'(NEAR_LIMIT)) && (err_comb <= 18'(NEAR_LIMIT));
      aligned_e <= (angle_p >= -16'(ALIGN_LIMIT)) && (angle_p <= 16'(ALIGN_LIMIT));
    end
  end

  // Gain products, already gated by the flags.
  logic signed [34:0] term_d;
  logic signed [32:0] term_a;
  logic signed [15:0] dist_m;
  logic signed [15:0] angle_m;
  logic               near_m;
  logic               aligned_m;

  always_ff @(posedge clk) begin
    if (adv) begin
      term_d    <= aligned_e ? 35'($signed({1'b0, distance_gain})) * 35'(err_e) : '0;
      term_a    <= near_e ? 33'($signed({1'b0, angle_gain})) * 33'(angle_e) : '0;
      dist_m    <= dist_e;
      angle_m   <= angle_e;
      near_m    <= near_e;
      aligned_m <= aligned_e;
    end
  end

  // Turn command and wheel speeds into the output register.
  logic signed [WIDE_W-1:0] turn;
  logic signed [WIDE_W-1:0] base_w;

  assign turn   = ((WIDE_W'(term_d) <<< 6) - WIDE_W'(term_a)) >>> 14;
  assign base_w = WIDE_W'(base_speed);

  always_ff @(posedge clk) begin
    if (adv) begin
      right_wheel_speed <= sat16(turn - base_w);
      left_wheel_speed  <= sat16(-base_w - turn);
      wall_distance     <= dist_m;
      wall_angle        <= angle_m;
      near_wall         <= near_m;
      aligned           <= aligned_m;
    end
  end

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (wall_angle <= 16'(ANGLE_LIMIT)) && (wall_angle >= -16'(ANGLE_LIMIT)))
    else $error("wall angle outside its clamp");

  a_aligned_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> aligned ==
      ((wall_angle <= 16'(ALIGN_LIMIT)) && (wall_angle >= -16'(ALIGN_LIMIT))))
    else $error("aligned flag disagrees with wall angle");

  a_no_turn: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !aligned && !near_wall) |-> right_wheel_speed == left_wheel_speed)
    else $error("turn applied with both terms gated off");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("stage valid bits moved during a stall");

endmodule
`default_nettype wire

// ===== tb/ir_wall_follow_steering_checker.sv =====
// Checker for the wall-following steering block: computes expected steering and compares.
`timescale 1ns / 1ps
module ir_wall_follow_steering_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [9:0]         front_sample,
  input  wire logic [9:0]         rear_sample,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [15:0] right_wheel_speed,
  input  wire logic signed [15:0] left_wheel_speed,
  input  wire logic signed [15:0] wall_distance,
  input  wire logic signed [15:0] wall_angle,
  input  wire logic               near_wall,
  input  wire logic               aligned,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output int                      fail_count,
  output int                      pending
);
  import irwfs_pkg::*;

  typedef struct packed {
    logic signed [15:0] right;
    logic signed [15:0] left;
    logic signed [15:0] distance;
    logic signed [15:0] angle;
    logic               near;
    logic               align;
  } steer_t;

  steer_t steer_q[$];

  logic [15:0] f_scale, r_scale, tgt, d_gain, a_gain, base;
  logic [9:0]  f_bias, r_bias;

  localparam longint ATAN_TAB [15] = '{12868, 7596, 4014, 2037, 1023, 512, 256, 128,
                                      64, 32, 16, 8, 4, 2, 1};

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Integer division in SystemVerilog truncates toward zero, as required.
  function automatic longint range_cm(logic [9:0] s, logic [15:0] scale, logic [9:0] bias,
                                      longint offs);
    longint den, num, q;
    den = longint'(s) + longint'($signed(bias));
    num = longint'(scale) * 256;
    if (den == 0) q = (num != 0) ? 32767 : 0;
    else q = clip16(num / den);
    return clip16(q - offs);
  endfunction

  function automatic longint arctan_q14(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    x = x * 4096;
    y = y * 4096;
    for (int i = 0; i < 15; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += ATAN_TAB[i];
      end else begin
        x = x - ys; y = y + xs; z -= ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic longint cosine_q14(longint a);
    longint x, y, z, xs, ys;
    x = 9949 * 256;
    y = 0;
    z = a;
    for (int i = 0; i < 15; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z -= ATAN_TAB[i];
      end else begin
        x = x + ys; y = y - xs; z += ATAN_TAB[i];
      end
    end
    return x >>> 8;
  endfunction

  function automatic steer_t predict_steering(logic [9:0] fs, logic [9:0] rs);
    longint f, r, diff, ang, wdist, err, w, v;
    steer_t s;
    f = range_cm(fs, f_scale, f_bias, 0);
    r = range_cm(rs, r_scale, r_bias, 0);
    diff = f - r;
    ang = (diff == 0) ? 0 : -arctan_q14(diff, 4096);
    if (ang > 25736) ang = 25736;
    if (ang < -25736) ang = -25736;
    wdist = clip16((((f + r) >>> 1) * cosine_q14(ang)) >>> 14);
    err = wdist - longint'(tgt);
    s.near = (err >= -2560 && err <= 2560);
    s.align = (ang >= -3276 && ang <= 3276);
    w = 0;
    if (s.align) w += longint'(d_gain) * err * 64;
    if (s.near) w -= longint'(a_gain) * ang;
    w = w >>> 14;
    v = longint'($signed(base));
    s.right = 16'(clip16(w - v));
    s.left = 16'(clip16(-v - w));
    s.distance = 16'(wdist);
    s.angle = 16'(ang);
    return s;
  endfunction

  assign pending = steer_q.size();

  always_ff @(posedge clk) begin
    steer_t exp_s;
    if (rst) begin
      f_scale <= '0; f_bias <= '0; r_scale <= '0; r_bias <= '0;
      tgt <= '0; d_gain <= '0; a_gain <= '0; base <= '0;
      fail_count <= 0;
      steer_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRONT_SCALE:     f_scale <= cfg_data;
          REG_FRONT_BIAS:      f_bias <= cfg_data[9:0];
          REG_REAR_SCALE:      r_scale <= cfg_data;
          REG_REAR_BIAS:       r_bias <= cfg_data[9:0];
          REG_TARGET_DISTANCE: tgt <= cfg_data;
          REG_DISTANCE_GAIN:   d_gain <= cfg_data;
          REG_ANGLE_GAIN:      a_gain <= cfg_data;
          REG_BASE_SPEED:      base <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) steer_q.push_back(predict_steering(front_sample, rear_sample));
      if (out_valid && out_ready) begin
        if (steer_q.size() == 0) begin
          $error("steering result with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_s = steer_q.pop_front();
          if (exp_s.right !== right_wheel_speed || exp_s.left !== left_wheel_speed ||
              exp_s.distance !== wall_distance || exp_s.angle !== wall_angle ||
              exp_s.near !== near_wall || exp_s.align !== aligned) begin
            fail_count <= fail_count + 1;
            if (exp_s.right !== right_wheel_speed)
              $error("right_wheel_speed expected %0d got %0d", exp_s.right, right_wheel_speed);
            if (exp_s.left !== left_wheel_speed)
              $error("left_wheel_speed expected %0d got %0d", exp_s.left, left_wheel_speed);
            if (exp_s.distance !== wall_distance)
              $error("wall_distance expected %0d got %0d", exp_s.distance, wall_distance);
            if (exp_s.angle !== wall_angle)
              $error("wall_angle expected %0d got %0d", exp_s.angle, wall_angle);
            if (exp_s.near !== near_wall)
              $error("near_wall expected %0b got %0b", exp_s.near, near_wall);
            if (exp_s.align !== aligned)
              $error("aligned expected %0b got %0b", exp_s.align, aligned);
          end
        end
      end
    end
  end
endmodule

// ===== tb/ir_wall_follow_steering_tb.sv =====
// Top of the wall-following steering testbench: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module ir_wall_follow_steering_tb;
  import irwfs_pkg::*;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [9:0] front_sample, rear_sample;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;
  logic signed [15:0] right_wheel_speed, left_wheel_speed, wall_distance, wall_angle;
  logic near_wall, aligned;
  int fail_count, pending;
  int idle_cycles;

  ir_wall_follow_steering dut (.*);

  ir_wall_follow_steering_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The watchdog counts cycles in which no transfer of any kind takes place. The block
  // holds a result only while it passes the pipeline and while the receiver stalls, and the
  // sender idles only for its drawn gaps and while settling, so a quiet stretch past the limit means a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver draws a fresh stall before each result; now and then no stall is drawn
  // at all so that results can be drained back to back.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
    end
  end

  // Sends one sensor pair, waiting the given number of cycles first. Valid stays high from
  // one transfer to the next when the gap is zero.
  task automatic send_pair(input logic [9:0] fs, input logic [9:0] rs, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    front_sample <= fs;
    rear_sample <= rs;
    @(posedge clk iff in_ready);
  endtask

  // Valid stays high across a run of writes; the caller drops it at the end.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk iff cfg_ready);
  endtask

  // Waits for every expected result, then lets the pipeline drain fully before any write.
  task automatic settle;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  task automatic load_setting(input logic [15:0] fsc, input logic [9:0] fb,
                              input logic [15:0] rsc, input logic [9:0] rb,
                              input logic [15:0] tg, input logic [15:0] dg,
                              input logic [15:0] ag, input logic [15:0] bs);
    write_reg(REG_FRONT_SCALE, fsc);
    write_reg(REG_FRONT_BIAS, {{6{fb[9]}}, fb});
    write_reg(REG_REAR_SCALE, rsc);
    write_reg(REG_REAR_BIAS, {{6{rb[9]}}, rb});
    write_reg(REG_TARGET_DISTANCE, tg);
    write_reg(REG_DISTANCE_GAIN, dg);
    write_reg(REG_ANGLE_GAIN, ag);
    write_reg(REG_BASE_SPEED, bs);
    cfg_valid <= 1'b0;
  endtask

  // Mostly small sample values give distances in the useful range; the rest cover the
  // whole ten-bit field.
  function automatic logic [9:0] pick_sample;
    return ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(100, 600));
  endfunction

  function automatic int pick_gap;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
  endfunction

  initial begin
    logic [9:0] fs;
    rst = 1'b1;
    in_valid = 1'b0;
    front_sample = '0;
    rear_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With every register at its reset value the distances are all zero.
    send_pair(10'd0, 10'd0, 0);
    send_pair(10'd1023, 10'd1023, 0);
    settle();

    // A realistic setting: equal distances give a zero angle, and a zero denominator
    // saturates the quotient.
    load_setting(16'd20000, -10'sd100, 16'd20000, -10'sd100, 16'd12800, 16'd256, 16'd512,
                 16'd2560);
    send_pair(10'd300, 10'd300, 0);
    send_pair(10'd100, 10'd300, 0);
    send_pair(10'd300, 10'd100, 1);
    send_pair(10'd101, 10'd102, 0);
    send_pair(10'd0, 10'd1023, 2);
    send_pair(10'd1023, 10'd0, 0);
    send_pair(10'd250, 10'd260, 0);
    send_pair(10'd350, 10'd340, 3);
    settle();

    // Extremes: largest scales, most negative and most positive bias, wheel saturation.
    load_setting(16'hffff, -10'sd512, 16'hffff, 10'sd511, 16'hffff, 16'hffff, 16'hffff,
                 16'h8000);
    send_pair(10'd512, 10'd0, 0);
    send_pair(10'd0, 10'd512, 0);
    send_pair(10'd1023, 10'd1023, 0);
    send_pair(10'd511, 10'd513, 0);
    send_pair(10'd600, 10'd0, 0);
    settle();

    load_setting(16'd0, 10'sd511, 16'd0, -10'sd512, 16'd0, 16'd0, 16'd0, 16'h7fff);
    send_pair(10'd0, 10'd512, 0);
    send_pair(10'd1023, 10'd0, 0);
    settle();

    // Random phases: one setting each, mostly sensible, every third one fully random.
    for (int phase = 0; phase < 10; phase++) begin
      if (phase % 3 == 2)
        load_setting(16'($urandom), 10'($urandom), 16'($urandom), 10'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else
        load_setting(16'($urandom_range(5000, 40000)), 10'($urandom_range(0, 60)),
                     16'($urandom_range(5000, 40000)), 10'($urandom_range(0, 60)),
                     16'($urandom_range(2000, 20000)), 16'($urandom_range(0, 2048)),
                     16'($urandom_range(0, 2048)), 16'($urandom_range(0, 2048) - 1024));
      for (int n = 0; n < 100; n++) begin
        fs = pick_sample();
        // Often keep the two samples close so that the aligned branch is exercised.
        if ($urandom_range(0, 1) == 0)
          send_pair(fs, 10'(fs + $urandom_range(0, 8) - 4), pick_gap());
        else
          send_pair(fs, pick_sample(), pick_gap());
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
